>>> hw/rtl/pgsc_pkg.sv
`default_nettype none

package pgsc_pkg;

    // Field widths.
    localparam int CMD_W      = 3;
    localparam int KEY_W      = 3;
    localparam int KIND_W     = 2;
    localparam int DIR_W      = 2;
    localparam int FREQ_W     = 20;
    localparam int DUTY_W     = 7;
    localparam int REQ_DUTY_W = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 64;

    // Period divider: 1000000 plus half the frequency fits 21 bits.
    localparam int DIVIDEND_W = 21;
    localparam int DIVISOR_W  = 20;

    // Pulse: period * duty + 50 fits 23 bits. The division by 100 is a
    // multiplication by ceil(2^30 / 100) and a shift by 30, exact for every
    // value of that width.
    localparam int PROD_W      = 23;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_KEY      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROTATE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_FREQ = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_DUTY = 3'd5;

    // Key identities and press kinds.
    localparam logic [KEY_W-1:0]  KEY_DOWN   = 3'd0;
    localparam logic [KEY_W-1:0]  KEY_UP     = 3'd1;
    localparam logic [KEY_W-1:0]  KEY_DUTY   = 3'd2;
    localparam logic [KEY_W-1:0]  KEY_TOGGLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;
    localparam logic [DIR_W-1:0]  DIR_NONE    = 2'd0;
    localparam logic [DIR_W-1:0]  DIR_FORWARD = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_MAX = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MIN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MAX = 2'd3;

    // Reset values.
    localparam logic [FREQ_W-1:0] FREQ_MIN_RESET = 20'd20;
    localparam logic [FREQ_W-1:0] FREQ_MAX_RESET = 20'd20000;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RESET = 7'd5;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 7'd95;
    localparam logic [FREQ_W-1:0] FREQ_RESET     = 20'd1000;
    localparam logic [DUTY_W-1:0] DUTY_RESET     = 7'd50;

    // Arithmetic constants.
    localparam logic [FREQ_W:0]     TIMER_HZ    = 21'd1000000;
    localparam logic [DUTY_W-1:0]   DUTY_STEP   = 7'd5;
    localparam logic [DUTY_W-1:0]   PULSE_ROUND = 7'd50;
    localparam logic [DUTY_W-1:0]   PCT_DIV     = 7'd100;
    localparam logic [TICK_W-1:0]   TICK_MAX    = 16'd65535;
    localparam logic [TICK_W-1:0]   PERIOD_MIN  = 16'd2;

    localparam int PRESET_COUNT = 10;
    localparam logic [FREQ_W-1:0] PRESET_HZ [PRESET_COUNT] = '{
        20'd20, 20'd50, 20'd100, 20'd200, 20'd500,
        20'd1000, 20'd2000, 20'd5000, 20'd10000, 20'd20000
    };

    typedef struct packed {
        logic                    prior_run;
        logic [TICK_W-1:0]       prior_pulse;
        logic [TICK_W-1:0]       prior_period;
        logic [REQ_DUTY_W-1:0]   target_duty;
        logic [FREQ_W-1:0]       target_hz;
        logic signed [DIR_W-1:0] direction;
        logic [KIND_W-1:0]       key_kind;
        logic [KEY_W-1:0]        key_id;
        logic [CMD_W-1:0]        cmd;
    } t_item;

    typedef struct packed {
        logic              gen_active;
        logic              out_enabled;
        logic [DUTY_W-1:0] duty_now;
        logic [FREQ_W-1:0] freq_now;
        logic              pwm_run;
        logic [TICK_W-1:0] pwm_pulse;
        logic [TICK_W-1:0] pwm_period;
        logic              pwm_written;
    } t_result;

    typedef struct packed {
        logic accept;
        logic per_start;
        logic per_store;
        logic mul;
        logic pul_mul;
        logic pul_store;
        logic out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic need_apply;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/pgsc_div.sv
`default_nettype none

module pgsc_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0] w_shift;
    logic [DIVISOR_W:0] w_diff;
    logic               w_ge;

    // One quotient bit per cycle, restoring form.
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/pgsc_ctrl.sv
`default_nettype none

module pgsc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire pgsc_pkg::t_dp_status  i_status,
    output pgsc_pkg::t_dp_ctrl         o_ctrl
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_PER_LOAD  = 7'b0000010,
        S_PER_DIV   = 7'b0000100,
        S_MUL       = 7'b0001000,
        S_PUL_MUL   = 7'b0010000,
        S_PUL_STORE = 7'b0100000,
        S_OUT       = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.accept = 1'b1;
                    n_state = i_status.need_apply ? S_PER_LOAD : S_OUT;
                end
            end
            S_PER_LOAD: begin
                o_ctrl.per_start = 1'b1;
                n_state = S_PER_DIV;
            end
            S_PER_DIV: begin
                if (i_status.div_done) begin
                    o_ctrl.per_store = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctrl.mul = 1'b1;
                n_state = S_PUL_MUL;
            end
            S_PUL_MUL: begin
                o_ctrl.pul_mul = 1'b1;
                n_state = S_PUL_STORE;
            end
            S_PUL_STORE: begin
                o_ctrl.pul_store = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Wait here only while the previous result is still unclaimed.
                if (i_status.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pgsc_dpath.sv
`default_nettype none

module pgsc_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pgsc_pkg::t_dp_ctrl                  i_ctrl,
    output pgsc_pkg::t_dp_status                     o_status,
    input  wire pgsc_pkg::t_item                     i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [pgsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [pgsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                                i_m_ready,
    output logic                                     o_m_valid,
    output pgsc_pkg::t_result                        o_result
);

    localparam int FW  = pgsc_pkg::FREQ_W;
    localparam int DW  = pgsc_pkg::DUTY_W;
    localparam int TW  = pgsc_pkg::TICK_W;
    localparam int NW  = pgsc_pkg::DIVIDEND_W;
    localparam int VW  = pgsc_pkg::DIVISOR_W;
    localparam int PW  = pgsc_pkg::PROD_W;
    localparam int MW  = pgsc_pkg::PROD_W + pgsc_pkg::RECIP_W;
    localparam int SH  = pgsc_pkg::RECIP_SHIFT;
    localparam int QW  = MW - SH;

    function automatic logic [FW-1:0] clamp_freq(
        input logic [FW-1:0] v, input logic [FW-1:0] lo, input logic [FW-1:0] hi);
        logic [FW-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // The value may be one bit wider than the limits; a result that passes
    // the upper compare always fits the duty width.
    function automatic logic [DW-1:0] clamp_duty(
        input logic [DW:0] v, input logic [DW-1:0] lo, input logic [DW-1:0] hi);
        logic [DW-1:0] r;
        if (v < {1'b0, lo}) begin
            r = lo;
        end else if (v > {1'b0, hi}) begin
            r = hi;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // Configuration.
    logic [FW-1:0] r_freq_min;
    logic [FW-1:0] r_freq_max;
    logic [DW-1:0] r_duty_min;
    logic [DW-1:0] r_duty_max;

    // Generator state.
    logic [FW-1:0] r_freq;
    logic [DW-1:0] r_duty;
    logic          r_enable;
    logic          r_active;
    logic [TW-1:0] r_saved_period;
    logic [TW-1:0] r_saved_pulse;
    logic          r_saved_run;
    logic [TW-1:0] r_timer_period;
    logic [TW-1:0] r_timer_pulse;
    logic          r_timer_run;
    logic          r_written;

    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_pul_quo;
    logic              r_m_valid;
    pgsc_pkg::t_result r_out;

    // Item decode.
    logic [FW-1:0] w_next;
    logic [FW-1:0] w_prev;
    logic [DW:0]   w_duty_up;
    logic [DW:0]   w_duty_dn;
    logic [FW-1:0] w_freq_val;
    logic [DW:0]   w_duty_val;
    logic          w_freq_we;
    logic          w_duty_we;
    logic          w_start;
    logic          w_stop;
    logic          w_toggle;
    logic          w_need_apply;

    // Arithmetic.
    logic [FW:0]   w_per_num;
    logic          w_div_start;
    logic [NW-1:0] w_dividend;
    logic [VW-1:0] w_divisor;
    logic          w_div_done;
    logic [NW-1:0] w_quo;
    logic [TW-1:0] w_period;
    logic [TW-1:0] w_pulse;
    logic [PW-1:0] w_prod;
    logic [MW-1:0] w_recip;

    always_comb begin
        w_next = r_freq_max;
        for (int i = pgsc_pkg::PRESET_COUNT - 1; i >= 0; i--) begin
            if (pgsc_pkg::PRESET_HZ[i] > r_freq) begin
                w_next = pgsc_pkg::PRESET_HZ[i];
            end
        end
    end

    always_comb begin
        w_prev = r_freq_min;
        for (int i = 0; i < pgsc_pkg::PRESET_COUNT; i++) begin
            if (pgsc_pkg::PRESET_HZ[i] < r_freq) begin
                w_prev = pgsc_pkg::PRESET_HZ[i];
            end
        end
    end

    assign w_duty_up = {1'b0, r_duty} + {1'b0, pgsc_pkg::DUTY_STEP};
    assign w_duty_dn = (r_duty > pgsc_pkg::DUTY_STEP) ?
                       {1'b0, r_duty - pgsc_pkg::DUTY_STEP} : '0;

    always_comb begin
        w_freq_val = i_item.target_hz;
        w_duty_val = i_item.target_duty;
        w_freq_we  = 1'b0;
        w_duty_we  = 1'b0;
        w_start    = 1'b0;
        w_stop     = 1'b0;
        w_toggle   = 1'b0;
        unique case (i_item.cmd)
            pgsc_pkg::CMD_START: w_start = !r_active;
            pgsc_pkg::CMD_STOP:  w_stop  = r_active;
            pgsc_pkg::CMD_KEY: begin
                if (r_active) begin
                    if (i_item.key_id == pgsc_pkg::KEY_DOWN &&
                        i_item.key_kind == pgsc_pkg::KIND_SINGLE) begin
                        w_freq_val = w_prev;
                        w_freq_we  = 1'b1;
                    end else if (i_item.key_id == pgsc_pkg::KEY_UP &&
                                 i_item.key_kind == pgsc_pkg::KIND_SINGLE) begin
                        w_freq_val = w_next;
                        w_freq_we  = 1'b1;
                    end else if (i_item.key_id == pgsc_pkg::KEY_DUTY) begin
                        if (i_item.key_kind == pgsc_pkg::KIND_SINGLE) begin
                            w_duty_val = w_duty_up;
                            w_duty_we  = 1'b1;
                        end else if (i_item.key_kind == pgsc_pkg::KIND_DOUBLE &&
                                     r_duty > r_duty_min) begin
                            w_duty_val = w_duty_dn;
                            w_duty_we  = 1'b1;
                        end
                    end else if (i_item.key_id == pgsc_pkg::KEY_TOGGLE &&
                                 i_item.key_kind == pgsc_pkg::KIND_SINGLE) begin
                        w_toggle = 1'b1;
                    end
                end
            end
            pgsc_pkg::CMD_ROTATE: begin
                if (r_active && i_item.direction != pgsc_pkg::DIR_NONE) begin
                    // Any negative step goes to the previous preset.
                    w_freq_val = (i_item.direction == pgsc_pkg::DIR_FORWARD) ?
                                 w_next : w_prev;
                    w_freq_we  = 1'b1;
                end
            end
            pgsc_pkg::CMD_SET_FREQ: w_freq_we = 1'b1;
            pgsc_pkg::CMD_SET_DUTY: w_duty_we = 1'b1;
            default: ;
        endcase
    end

    assign w_need_apply = w_start | (r_active & (w_freq_we | w_duty_we));

    // The divider serves the period only; the pulse divides by 100 through
    // a reciprocal multiplication.
    assign w_per_num   = pgsc_pkg::TIMER_HZ + {2'b0, r_freq[FW-1:1]};
    assign w_div_start = i_ctrl.per_start;
    assign w_dividend  = w_per_num;
    assign w_divisor   = r_freq;

    pgsc_div #(
        .DIVIDEND_W (NW),
        .DIVISOR_W  (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        if (r_freq == '0) begin
            w_period = pgsc_pkg::TICK_MAX;
        end else if (w_quo < NW'(pgsc_pkg::PERIOD_MIN)) begin
            w_period = pgsc_pkg::PERIOD_MIN;
        end else if (w_quo > NW'(pgsc_pkg::TICK_MAX)) begin
            w_period = pgsc_pkg::TICK_MAX;
        end else begin
            w_period = w_quo[TW-1:0];
        end
    end

    always_comb begin
        if (r_pul_quo == '0) begin
            w_pulse = TW'(1);
        end else if (r_pul_quo >= QW'(r_timer_period)) begin
            w_pulse = r_timer_period - TW'(1);
        end else begin
            w_pulse = r_pul_quo[TW-1:0];
        end
    end

    assign w_prod  = PW'(r_timer_period) * PW'(r_duty);
    assign w_recip = MW'(r_prod) * MW'(pgsc_pkg::PCT_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= w_prod + PW'(pgsc_pkg::PULSE_ROUND);
        end
        if (i_ctrl.pul_mul) begin
            r_pul_quo <= w_recip[MW-1:SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_min <= pgsc_pkg::FREQ_MIN_RESET;
            r_freq_max <= pgsc_pkg::FREQ_MAX_RESET;
            r_duty_min <= pgsc_pkg::DUTY_MIN_RESET;
            r_duty_max <= pgsc_pkg::DUTY_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pgsc_pkg::CFG_FREQ_MIN: r_freq_min <= i_cfg_wdata[FW-1:0];
                pgsc_pkg::CFG_FREQ_MAX: r_freq_max <= i_cfg_wdata[FW-1:0];
                pgsc_pkg::CFG_DUTY_MIN: r_duty_min <= i_cfg_wdata[DW-1:0];
                pgsc_pkg::CFG_DUTY_MAX: r_duty_max <= i_cfg_wdata[DW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq         <= pgsc_pkg::FREQ_RESET;
            r_duty         <= pgsc_pkg::DUTY_RESET;
            r_enable       <= 1'b0;
            r_active       <= 1'b0;
            r_saved_period <= '0;
            r_saved_pulse  <= '0;
            r_saved_run    <= 1'b0;
            r_timer_period <= '0;
            r_timer_pulse  <= '0;
            r_timer_run    <= 1'b0;
            r_written      <= 1'b0;
        end else begin
            if (i_ctrl.accept) begin
                r_written <= w_need_apply | w_stop | w_toggle;
                if (w_freq_we) begin
                    r_freq <= clamp_freq(w_freq_val, r_freq_min, r_freq_max);
                end
                if (w_duty_we) begin
                    r_duty <= clamp_duty(w_duty_val, r_duty_min, r_duty_max);
                end
                if (w_start) begin
                    r_saved_period <= i_item.prior_period;
                    r_saved_pulse  <= i_item.prior_pulse;
                    r_saved_run    <= i_item.prior_run;
                    r_active       <= 1'b1;
                    r_enable       <= 1'b1;
                end
                if (w_stop) begin
                    r_active       <= 1'b0;
                    r_enable       <= 1'b0;
                    r_timer_period <= r_saved_period;
                    r_timer_pulse  <= r_saved_pulse;
                    r_timer_run    <= r_saved_run;
                end
                if (w_toggle) begin
                    r_enable    <= !r_enable;
                    r_timer_run <= !r_enable;
                end
            end
            if (i_ctrl.per_store) begin
                r_timer_period <= w_period;
            end
            if (i_ctrl.pul_store) begin
                r_timer_pulse <= w_pulse;
                r_timer_run   <= r_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out.pwm_written <= r_written;
            r_out.pwm_period  <= r_timer_period;
            r_out.pwm_pulse   <= r_timer_pulse;
            r_out.pwm_run     <= r_timer_run;
            r_out.freq_now    <= r_freq;
            r_out.duty_now    <= r_duty;
            r_out.out_enabled <= r_enable;
            r_out.gen_active  <= r_active;
        end
    end

    assign o_status.need_apply = w_need_apply;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = !r_m_valid || i_m_ready;
    assign o_m_valid           = r_m_valid;
    assign o_result            = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/pwm_generator_settings_control.sv
// Channel        | Direction | Handshake                      | Carries
// ---------------+-----------+--------------------------------+---------------------------
// s_axis         | in        | s_axis_tvalid / s_axis_tready  | one command request
// m_axis         | out       | m_axis_tvalid / m_axis_tready  | one result per command
// cfg            | in        | i_cfg_we (no wait)             | frequency and duty limits
//
// A command that starts the generator, or changes frequency or duty while it is active,
// passes through acceptance, the start of the 21-step period divider, the wait on it,
// the duty product, the reciprocal divide by 100, the pulse store and the result load;
// any other command goes from acceptance straight to the result load. A new request is
// taken once the previous command has put its result in the output register; the load
// waits only while the result before it is unclaimed. Reset is synchronous and active
// low and restores all limits and generator state.
`default_nettype none

module pwm_generator_settings_control (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [2:0] key_id, [4:3] key_kind, [6:5] direction, [26:7] target_hz,
    // [34:27] target_duty, [50:35] prior_period, [66:51] prior_pulse,
    // [67] prior_run, [71:68] zero
    input  wire logic [pgsc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [2:0] cmd
    input  wire logic [pgsc_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] pwm_written, [16:1] pwm_period, [32:17] pwm_pulse, [33] pwm_run,
    // [53:34] freq_now, [60:54] duty_now, [61] out_enabled, [62] gen_active,
    // [63] zero
    output logic [pgsc_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [pgsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [pgsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    pgsc_pkg::t_item      w_item;
    pgsc_pkg::t_result    w_result;
    pgsc_pkg::t_dp_ctrl   w_ctrl;
    pgsc_pkg::t_dp_status w_status;

    assign w_item.cmd          = s_axis_tuser;
    assign w_item.key_id       = s_axis_tdata[2:0];
    assign w_item.key_kind     = s_axis_tdata[4:3];
    assign w_item.direction    = s_axis_tdata[6:5];
    assign w_item.target_hz    = s_axis_tdata[26:7];
    assign w_item.target_duty  = s_axis_tdata[34:27];
    assign w_item.prior_period = s_axis_tdata[50:35];
    assign w_item.prior_pulse  = s_axis_tdata[66:51];
    assign w_item.prior_run    = s_axis_tdata[67];

    pgsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    pgsc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {1'b0,
                           w_result.gen_active,
                           w_result.out_enabled,
                           w_result.duty_now,
                           w_result.freq_now,
                           w_result.pwm_run,
                           w_result.pwm_pulse,
                           w_result.pwm_period,
                           w_result.pwm_written};

endmodule

`default_nettype wire
